/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define SCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define SCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/core/scc_wsm_pkg.sv */
package scc_wsm_pkg;

    localparam int PHASE_W  = 32;
    localparam int DIGIT_W  = 4;
    localparam int PERIOD_W = 12;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
    } phase_add_req_t;

    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] sum;
    } phase_add_out_t;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] period;
    } step_div_req_t;

    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] step;
    } step_div_out_t;

endpackage

/* rtl/core/scc_wsm_ram.sv */
module scc_wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/scc_wsm_phase_add.sv */
module scc_wsm_phase_add
    import scc_wsm_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  phase_add_req_t req,
    output phase_add_out_t res
);

    localparam int STEPS = PHASE_W / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [PHASE_W-1:0] a_sh_reg, a_sh_next;
    logic [PHASE_W-1:0] b_sh_reg, b_sh_next;
    logic               carry_reg, carry_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [DIGIT_W:0]   digit_sum;

    always_comb begin
        digit_sum  = {1'b0, a_sh_reg[DIGIT_W-1:0]} + {1'b0, b_sh_reg[DIGIT_W-1:0]}
                   + {{DIGIT_W{1'b0}}, carry_reg};
        a_sh_next  = a_sh_reg;
        b_sh_next  = b_sh_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (req.start) begin
            a_sh_next  = req.phase;
            b_sh_next  = req.step;
            carry_next = 1'b0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end else if (run_reg) begin
            // low digit first, sum digits enter at the top
            a_sh_next  = {digit_sum[DIGIT_W-1:0], a_sh_reg[PHASE_W-1:DIGIT_W]};
            b_sh_next  = {{DIGIT_W{1'b0}}, b_sh_reg[PHASE_W-1:DIGIT_W]};
            carry_next = digit_sum[DIGIT_W];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
        end else begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            carry_reg <= carry_next;
        end
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign res.done = done_reg;
    assign res.sum  = a_sh_reg;

endmodule

/* rtl/core/scc_wsm_step_div.sv */
module scc_wsm_step_div
    import scc_wsm_pkg::*;
#(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  step_div_req_t req,
    output step_div_out_t res
);

    localparam int CLOCK_HZ  = 3579545;
    localparam int NUM_SHIFT = 27;
    localparam int NUM_W     = $clog2(CLOCK_HZ) + NUM_SHIFT;
    localparam int BIT_W     = $clog2(NUM_W);
    localparam int DEN_W     = $clog2((longint'(1) << PERIOD_W) * SAMPLE_RATE + 1);

    localparam logic [NUM_W-1:0] STEP_NUM = NUM_W'(longint'(CLOCK_HZ) << NUM_SHIFT);
    localparam logic [DEN_W-1:0] SR_CONST = DEN_W'(SAMPLE_RATE);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_RUN
    } dv_state_t;

    dv_state_t           state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [PHASE_W-1:0]  quot_reg, quot_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                done_reg, done_next;

    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                fits;
    logic [DEN_W-1:0]    tp1;

    always_comb begin
        trial       = {rem_reg, STEP_NUM[bit_reg]};
        diff        = trial - {1'b0, den_reg};
        fits        = trial >= {1'b0, den_reg};
        tp1         = DEN_W'(period_reg) + DEN_W'(1);
        state_next  = state_reg;
        period_next = period_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            DV_IDLE: begin
                if (req.start) begin
                    period_next = req.period;
                    state_next  = DV_MUL;
                end
            end
            DV_MUL: begin
                den_next   = tp1 * SR_CONST;
                rem_next   = '0;
                bit_next   = BIT_W'(NUM_W - 1);
                state_next = DV_RUN;
            end
            DV_RUN: begin
                // one quotient bit per cycle, only the low word is kept
                rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quot_next = {quot_reg[PHASE_W-2:0], fits};
                if (bit_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        period_reg <= period_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        bit_reg    <= bit_next;
    end

    assign res.done = done_reg;
    assign res.step = quot_reg;

endmodule

/* rtl/core/scc_wavetable_sound_mapper_core.sv */
// bus read: ST_OUT, then output register; register read: ST_R_READ, ST_R_DATA, ST_OUT
// bus write: done on accept; a period write runs the divider, one quotient bit per cycle
// sample tick: the 5 channels in turn, set by the 4-bit serial phase adder and ram port
// one item at a time; a finished result waits in the output register while the next one runs
// reset: state to defaults, then a clear of all 256 sound ram entries with s_ready low
`include "assert_macros.svh"

module scc_wavetable_sound_mapper_core
    import scc_wsm_pkg::*;
#(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [5:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [15:0]        s_address,
    input  logic [7:0]         s_write_data,
    input  logic [7:0]         s_core_register,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [18:0]        m_rom_address,
    output logic [7:0]         m_register_data,
    output logic signed [15:0] m_sample
);

    localparam logic [1:0]  CMD_READ     = 2'd0;
    localparam logic [1:0]  CMD_WRITE    = 2'd1;
    localparam logic [1:0]  CMD_TICK     = 2'd2;
    localparam logic [1:0]  CMD_REG_READ = 2'd3;
    localparam logic [12:0] SOUND_BASE   = 13'h1800;
    localparam logic [5:0]  SOUND_BANK   = 6'h3F;
    localparam logic [7:0]  REG_FREQ_LO  = 8'h80;
    localparam logic [7:0]  REG_FREQ_HI  = 8'h89;
    localparam logic [7:0]  REG_VOLUME   = 8'h8A;
    localparam logic [7:0]  REG_ENABLE   = 8'h8F;
    localparam logic [2:0]  LAST_CH      = 3'd4;
    localparam logic [1:0]  SHARED_WAVE  = 2'd3;
    localparam logic [7:0]  CLEAR_LAST   = 8'hFF;

    typedef logic [5:0]         bank_arr_t  [8];
    typedef logic [PHASE_W-1:0] phase_arr_t [5];

    localparam bank_arr_t BANK_RESET = '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd2, 6'd4};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_READ,
        ST_P_LOAD,
        ST_DIV,
        ST_R_READ,
        ST_R_DATA,
        ST_T_START,
        ST_T_VOL,
        ST_T_EN,
        ST_T_WAIT,
        ST_T_WAVE,
        ST_T_FIN,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         clear_cnt_reg, clear_cnt_next;
    bank_arr_t          bank_reg, bank_next;
    logic [5:0]         bank_mask_reg, bank_mask_next;
    logic [7:0]         sreg_reg, sreg_next;
    logic [7:0]         wdata_reg, wdata_next;
    logic [2:0]         ch_reg, ch_next;
    logic [3:0]         vol_reg, vol_next;
    logic               en_reg, en_next;
    logic signed [14:0] acc_reg, acc_next;
    phase_arr_t         phase_reg, phase_next;
    phase_arr_t         step_reg, step_next;
    logic [18:0]        res_rom_reg, res_rom_next;
    logic [7:0]         res_data_reg, res_data_next;
    logic [15:0]        res_sample_reg, res_sample_next;
    logic               m_valid_reg, m_valid_next;
    logic [18:0]        m_rom_reg, m_rom_next;
    logic [7:0]         m_data_reg, m_data_next;
    logic [15:0]        m_sample_reg, m_sample_next;

    logic               accept;
    logic [2:0]         in_page;
    logic [12:0]        in_offset;
    logic [5:0]         in_bank;
    logic               sound_hit;
    logic               freq_hit;
    logic               ram_we;
    logic [7:0]         ram_waddr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_raddr;
    logic [7:0]         ram_rd;
    logic [1:0]         wave_sel;
    logic signed [4:0]  vol_s;
    logic signed [12:0] prod;
    logic [16:0]        triple;

    phase_add_req_t     alu_req;
    phase_add_out_t     alu_res;
    step_div_req_t      div_req;
    step_div_out_t      div_res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign in_page   = s_address[15:13];
    assign in_offset = s_address[12:0];
    assign in_bank   = bank_reg[in_page];
    assign sound_hit = (in_offset[12:8] == SOUND_BASE[12:8]) && (in_bank == SOUND_BANK);
    assign freq_hit  = (in_offset[7:0] >= REG_FREQ_LO) && (in_offset[7:0] <= REG_FREQ_HI);

    assign ram_we    = (state_reg == ST_CLEAR)
                     || (accept && (s_command == CMD_WRITE) && sound_hit);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clear_cnt_reg : in_offset[7:0];
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 : s_write_data;
    assign wave_sel  = (ch_reg == LAST_CH) ? SHARED_WAVE : ch_reg[1:0];

    always_comb begin
        unique case (state_reg)
            ST_P_READ:  ram_raddr = {sreg_reg[7:1], ~sreg_reg[0]};
            ST_T_START: ram_raddr = REG_VOLUME + {5'd0, ch_reg};
            ST_T_VOL:   ram_raddr = REG_ENABLE;
            ST_T_WAIT:  ram_raddr = {1'b0, wave_sel, alu_res.sum[PHASE_W-1 -: 5]};
            default:    ram_raddr = sreg_reg;
        endcase
    end

    scc_wsm_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_sound_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd)
    );

    assign alu_req.start = (state_reg == ST_T_START);
    assign alu_req.phase = phase_reg[ch_reg];
    assign alu_req.step  = step_reg[ch_reg];

    scc_wsm_phase_add u_phase_add (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .res     (alu_res)
    );

    assign div_req.start  = (state_reg == ST_P_LOAD);
    assign div_req.period = sreg_reg[0] ? {wdata_reg[3:0], ram_rd} : {ram_rd[3:0], wdata_reg};

    scc_wsm_step_div #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_step_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    assign vol_s  = $signed({1'b0, (en_reg ? vol_reg : 4'd0)});
    assign prod   = $signed(ram_rd) * vol_s;
    assign triple = {acc_reg[14], acc_reg, 1'b0} + {{2{acc_reg[14]}}, acc_reg};

    always_comb begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        bank_next       = bank_reg;
        bank_mask_next  = cfg_wr_en ? cfg_wr_data : bank_mask_reg;
        sreg_next       = sreg_reg;
        wdata_next      = wdata_reg;
        ch_next         = ch_reg;
        vol_next        = vol_reg;
        en_next         = en_reg;
        acc_next        = acc_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        res_rom_next    = res_rom_reg;
        res_data_next   = res_data_reg;
        res_sample_next = res_sample_reg;
        m_valid_next    = m_valid_reg;
        m_rom_next      = m_rom_reg;
        m_data_next     = m_data_reg;
        m_sample_next   = m_sample_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == CLEAR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_rom_next    = '0;
                    res_data_next   = '0;
                    res_sample_next = '0;
                    unique case (s_command)
                        CMD_READ: begin
                            res_rom_next = {in_bank & bank_mask_reg, in_offset};
                            state_next   = ST_OUT;
                        end
                        CMD_WRITE: begin
                            if (in_offset < SOUND_BASE) begin
                                bank_next[in_page] = s_write_data[5:0];
                            end else if (sound_hit && freq_hit) begin
                                sreg_next  = in_offset[7:0];
                                wdata_next = s_write_data;
                                state_next = ST_P_READ;
                            end
                        end
                        CMD_TICK: begin
                            ch_next    = '0;
                            acc_next   = '0;
                            state_next = ST_T_START;
                        end
                        CMD_REG_READ: begin
                            sreg_next  = s_core_register;
                            state_next = ST_R_READ;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_P_READ: state_next = ST_P_LOAD;
            ST_P_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_res.done) begin
                    step_next[sreg_reg[3:1]] = div_res.step;
                    state_next               = ST_IDLE;
                end
            end
            ST_R_READ: state_next = ST_R_DATA;
            ST_R_DATA: begin
                res_data_next = ram_rd;
                state_next    = ST_OUT;
            end
            ST_T_START: state_next = ST_T_VOL;
            ST_T_VOL: begin
                vol_next   = ram_rd[3:0];
                state_next = ST_T_EN;
            end
            ST_T_EN: begin
                en_next    = ram_rd[ch_reg];
                state_next = ST_T_WAIT;
            end
            ST_T_WAIT: begin
                if (alu_res.done) begin
                    phase_next[ch_reg] = alu_res.sum;
                    state_next         = ST_T_WAVE;
                end
            end
            ST_T_WAVE: begin
                acc_next = acc_reg + {{2{prod[12]}}, prod};
                if (ch_reg == LAST_CH) begin
                    state_next = ST_T_FIN;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_T_START;
                end
            end
            ST_T_FIN: begin
                res_sample_next = triple[15:0];
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_rom_next    = res_rom_reg;
                    m_data_next   = res_data_reg;
                    m_sample_next = res_sample_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            bank_reg      <= BANK_RESET;
            bank_mask_reg <= '0;
            phase_reg     <= '{default: '0};
            step_reg      <= '{default: '0};
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            bank_reg      <= bank_next;
            bank_mask_reg <= bank_mask_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
        sreg_reg       <= sreg_next;
        wdata_reg      <= wdata_next;
        ch_reg         <= ch_next;
        vol_reg        <= vol_next;
        en_reg         <= en_next;
        acc_reg        <= acc_next;
        res_rom_reg    <= res_rom_next;
        res_data_reg   <= res_data_next;
        res_sample_reg <= res_sample_next;
        m_rom_reg      <= m_rom_next;
        m_data_reg     <= m_data_next;
        m_sample_reg   <= m_sample_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_rom_address   = m_rom_reg;
    assign m_register_data = m_data_reg;
    assign m_sample        = $signed(m_sample_reg);

    `SCC_ASSERT_IMP(a_alu_done_in_wait, aclk, aresetn, alu_res.done, state_reg == ST_T_WAIT, "phase adder finished outside wait state")
    `SCC_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_res.done, state_reg == ST_DIV, "divider finished outside divide state")
    `SCC_ASSERT_IMP(a_ram_write_state, aclk, aresetn, ram_we, (state_reg == ST_CLEAR) || (state_reg == ST_IDLE), "sound ram written during a busy sequence")
    `SCC_ASSERT_IMP(a_channel_range, aclk, aresetn, state_reg == ST_T_WAVE, ch_reg <= LAST_CH, "tick channel out of range")
    `SCC_ASSERT_NXT(a_out_load, aclk, aresetn, (state_reg == ST_OUT) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == ST_IDLE), "result not moved to output register")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import scc_wsm_pkg::*;

    localparam int          SAMPLE_RATE  = 44100;
    localparam longint      CLOCK_HZ     = 3579545;
    localparam int          PHASE_SHIFT  = 27;
    localparam logic [12:0] SOUND_BASE   = 13'h1800;
    localparam logic [5:0]  SOUND_BANK   = 6'h3F;
    localparam logic [7:0]  REG_FREQ_LO  = 8'h80;
    localparam logic [7:0]  REG_FREQ_HI  = 8'h89;
    localparam logic [7:0]  REG_VOLUME   = 8'h8A;
    localparam logic [7:0]  REG_ENABLE   = 8'h8F;
    localparam int          MAX_GAP      = 14;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          PHASE_ITEMS  = 320;
    localparam longint      CYCLE_LIMIT  = 2000000;

    typedef enum logic [1:0] {
        CMD_BUS_READ    = 2'd0,
        CMD_BUS_WRITE   = 2'd1,
        CMD_SAMPLE_TICK = 2'd2,
        CMD_REG_READ    = 2'd3
    } cmd_e;

    typedef struct {
        cmd_e        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  core_register;
    } bus_item_t;

    typedef struct {
        logic [18:0]        rom_address;
        logic [7:0]         register_data;
        logic signed [15:0] sample;
    } chip_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [5:0]         cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = '0;
    logic [15:0]        s_address = '0;
    logic [7:0]         s_write_data = '0;
    logic [7:0]         s_core_register = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [18:0]        m_rom_address;
    logic [7:0]         m_register_data;
    logic signed [15:0] m_sample;

    scc_wavetable_sound_mapper_core #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_address(s_address),
        .s_write_data(s_write_data),
        .s_core_register(s_core_register),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rom_address(m_rom_address),
        .m_register_data(m_register_data),
        .m_sample(m_sample)
    );

    always #5 aclk = ~aclk;

    // chip model state
    logic [5:0]  bank_sel [0:7];
    logic [7:0]  snd_reg [0:255];
    logic [31:0] phase_acc [0:4];
    logic [31:0] phase_step [0:4];
    logic [5:0]  rom_mask;

    // generator view of the bank registers, runs ahead of the model
    logic [5:0]  gen_bank [0:7];

    bus_item_t    pending_items [$];
    chip_result_t expected_results [$];

    int     errors = 0;
    longint cycle_count = 0;
    bit     in_fire = 1'b0;
    bit     out_fire = 1'b0;
    bit     in_burst = 1'b0;
    bit     out_burst = 1'b0;
    int     in_gap = 0;
    int     out_stall = 3;
    bus_item_t cur_item;

    function automatic logic [31:0] step_for_period(input logic [11:0] period);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(CLOCK_HZ) << PHASE_SHIFT;
        den = (64'(period) + 64'd1) * 64'(SAMPLE_RATE);
        quo = num / den;
        return quo[31:0];
    endfunction

    task automatic write_sound_reg(input logic [7:0] idx, input logic [7:0] value);
        int ch;
        logic [7:0] lo;
        snd_reg[idx] = value;
        if (idx >= REG_FREQ_LO && idx <= REG_FREQ_HI) begin
            ch = (idx - REG_FREQ_LO) >> 1;
            lo = REG_FREQ_LO + 8'(2 * ch);
            phase_step[ch] = step_for_period({snd_reg[lo + 8'd1][3:0], snd_reg[lo]});
        end
    endtask

    task automatic mix_sample(output logic signed [15:0] mixed);
        int acc;
        int wv;
        int vol;
        logic [4:0] idx;
        logic [7:0] base;
        logic signed [7:0] wb;
        acc = 0;
        for (int ch = 0; ch < 5; ch++) begin
            phase_acc[ch] = phase_acc[ch] + phase_step[ch];
            idx = phase_acc[ch][31:27];
            base = (ch < 4) ? 8'(ch * 32) : 8'd96;
            wb = snd_reg[base + {3'b000, idx}];
            wv = wb;
            vol = snd_reg[REG_ENABLE][ch] ? int'(snd_reg[REG_VOLUME + 8'(ch)][3:0]) : 0;
            acc += wv * vol;
        end
        acc = acc * 3;
        mixed = acc[15:0];
    endtask

    task automatic predict_item(input bus_item_t it);
        chip_result_t res;
        logic [2:0]  page;
        logic [12:0] offset;
        logic [12:0] reg_off;
        page = it.address[15:13];
        offset = it.address[12:0];
        res.rom_address = '0;
        res.register_data = '0;
        res.sample = '0;
        case (it.cmd)
            CMD_BUS_READ: begin
                res.rom_address = {bank_sel[page] & rom_mask, offset};
                expected_results.push_back(res);
            end
            CMD_BUS_WRITE: begin
                if (offset >= SOUND_BASE) begin
                    reg_off = offset - SOUND_BASE;
                    if (bank_sel[page] == SOUND_BANK && reg_off <= 13'd255)
                        write_sound_reg(reg_off[7:0], it.write_data);
                end else begin
                    bank_sel[page] = it.write_data[5:0];
                end
            end
            CMD_SAMPLE_TICK: begin
                mix_sample(res.sample);
                expected_results.push_back(res);
            end
            default: begin
                res.register_data = snd_reg[it.core_register];
                expected_results.push_back(res);
            end
        endcase
    endtask

    task automatic push_item(input cmd_e c, input logic [15:0] a, input logic [7:0] d);
        bus_item_t it;
        it.cmd = c;
        it.address = a;
        it.write_data = d;
        it.core_register = 8'($urandom);
        if (c == CMD_BUS_WRITE && a[12:0] < SOUND_BASE)
            gen_bank[a[15:13]] = d[5:0];
        pending_items.push_back(it);
    endtask

    task automatic push_reg_read(input logic [7:0] idx);
        bus_item_t it;
        it.cmd = CMD_REG_READ;
        it.address = 16'($urandom);
        it.write_data = 8'($urandom);
        it.core_register = idx;
        pending_items.push_back(it);
    endtask

    task automatic push_sound_write(input logic [7:0] idx, input logic [7:0] value);
        int open_pages [$];
        logic [2:0] page;
        for (int p = 0; p < 8; p++)
            if (gen_bank[p] == SOUND_BANK)
                open_pages.push_back(p);
        if (open_pages.size() == 0) begin
            page = 3'($urandom);
            push_item(CMD_BUS_WRITE, {page, 13'($urandom_range(0, 13'h17FF))},
                      {2'($urandom), SOUND_BANK});
        end else begin
            page = 3'(open_pages[$urandom_range(0, open_pages.size() - 1)]);
        end
        push_item(CMD_BUS_WRITE, {page, SOUND_BASE + {5'b00000, idx}}, value);
    endtask

    task automatic push_directed();
        push_item(CMD_BUS_READ, 16'h0000, 8'($urandom));
        push_item(CMD_BUS_READ, 16'hFFFF, 8'($urandom));
        push_item(CMD_BUS_READ, 16'hA123, 8'($urandom));
        // sound window in a page not switched to the sound bank
        push_item(CMD_BUS_WRITE, 16'h1FFF, 8'hAA);
        push_item(CMD_BUS_WRITE, 16'h0000, 8'hFF);
        push_item(CMD_BUS_READ, 16'h0010, 8'($urandom));
        push_item(CMD_BUS_WRITE, 16'hE000, 8'h3F);
        push_item(CMD_BUS_WRITE, 16'h1800, 8'h80);
        push_item(CMD_BUS_WRITE, 16'h1880, 8'h00);
        push_item(CMD_BUS_WRITE, 16'h1881, 8'hFF);
        push_item(CMD_BUS_WRITE, 16'h188A, 8'hFF);
        push_item(CMD_BUS_WRITE, 16'h188F, 8'hFF);
        // offsets past the register window
        push_item(CMD_BUS_WRITE, 16'h1900, 8'h55);
        push_item(CMD_BUS_WRITE, 16'hFFFF, 8'h12);
        push_item(CMD_SAMPLE_TICK, 16'($urandom), 8'($urandom));
        push_reg_read(8'h00);
        push_reg_read(8'h81);
        push_reg_read(8'hFF);
        push_item(CMD_BUS_WRITE, 16'hF8FF, 8'h7F);
        push_reg_read(8'hFF);
        push_item(CMD_BUS_WRITE, 16'h1888, 8'hFF);
        push_item(CMD_BUS_WRITE, 16'h1889, 8'h0F);
        push_item(CMD_SAMPLE_TICK, 16'($urandom), 8'($urandom));
        push_item(CMD_BUS_READ, 16'h5FFF, 8'($urandom));
        push_item(CMD_BUS_WRITE, 16'h1881, 8'h00);
        push_item(CMD_SAMPLE_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic push_random(input int count);
        int sel;
        int pick;
        logic [7:0] idx;
        logic [7:0] value;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                push_item(CMD_BUS_READ, 16'($urandom), 8'($urandom));
            end else if (sel < 35) begin
                value = ($urandom_range(0, 2) == 0) ? {2'($urandom), SOUND_BANK} : 8'($urandom);
                push_item(CMD_BUS_WRITE, {3'($urandom), 13'($urandom_range(0, 13'h17FF))},
                          value);
            end else if (sel < 65) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    idx = 8'($urandom_range(8'h80, 8'h8F));
                else if (pick < 8)
                    idx = 8'($urandom_range(8'h00, 8'h7F));
                else
                    idx = 8'($urandom_range(8'h90, 8'hFF));
                push_sound_write(idx, 8'($urandom));
            end else if (sel < 70) begin
                push_item(CMD_BUS_WRITE, {3'($urandom), 13'($urandom_range(13'h1800, 13'h1FFF))},
                          8'($urandom));
            end else if (sel < 88) begin
                push_item(CMD_SAMPLE_TICK, 16'($urandom), 8'($urandom));
            end else begin
                push_reg_read(8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    task automatic write_bank_mask(input logic [5:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        rom_mask = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 6'($urandom);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap--;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_command <= cur_item.cmd;
                s_address <= cur_item.address;
                s_write_data <= cur_item.write_data;
                s_core_register <= cur_item.core_register;
                if ($urandom_range(0, 63) == 0)
                    in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (out_fire) begin
            if ($urandom_range(0, 63) == 0)
                out_burst = !out_burst;
            out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (out_stall > 0) begin
            m_ready <= 1'b0;
            out_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        bus_item_t    taken;
        chip_result_t exp_res;
        in_fire = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            taken.cmd = cmd_e'(s_command);
            taken.address = s_address;
            taken.write_data = s_write_data;
            taken.core_register = s_core_register;
            predict_item(taken);
        end
        if (out_fire) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item: rom_address %h register_data %h sample %0d",
                         $time, m_rom_address, m_register_data, m_sample);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_rom_address !== exp_res.rom_address) begin
                    $display("%0t: rom_address expected %h actual %h",
                             $time, exp_res.rom_address, m_rom_address);
                    errors++;
                end
                if (m_register_data !== exp_res.register_data) begin
                    $display("%0t: register_data expected %h actual %h",
                             $time, exp_res.register_data, m_register_data);
                    errors++;
                end
                if (m_sample !== exp_res.sample) begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, exp_res.sample, m_sample);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [5:0] masks [0:4];
        for (int p = 0; p < 8; p++)
            bank_sel[p] = '0;
        bank_sel[5] = 6'd1;
        bank_sel[6] = 6'd2;
        bank_sel[7] = 6'd4;
        gen_bank = bank_sel;
        for (int r = 0; r < 256; r++)
            snd_reg[r] = '0;
        for (int ch = 0; ch < 5; ch++) begin
            phase_acc[ch] = '0;
            phase_step[ch] = '0;
        end
        rom_mask = '0;
        masks[0] = 6'd0;
        masks[1] = 6'($urandom);
        masks[2] = 6'h2A;
        masks[3] = 6'h3F;
        masks[4] = 6'($urandom);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // ram clear runs after reset
        repeat (4) @(posedge aclk);
        do begin
            @(posedge aclk);
            #1;
        end while (!s_ready);

        write_bank_mask(6'h3F);
        push_directed();
        push_random(PHASE_ITEMS);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            write_bank_mask(masks[ph]);
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
